// File: design/assert_macros.svh
// Assertion macros used by lcd_nibble_write_stream.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: design/lnws_pkg.sv
// Types, constants and the BCD adjust function for the LCD nibble write stream.
package lnws_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

	typedef logic [1:0]         cmd_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [3:0]         digit_cnt_t;

	localparam cmd_t CMD_INSTR  = 2'd0;
	localparam cmd_t CMD_CHAR   = 2'd1;
	localparam cmd_t CMD_NUMBER = 2'd2;

	// Low nibble of every expander byte: backlight, EN, unused, RS.
	localparam logic [3:0] CTRL_CMD_EN_HIGH  = 4'hC;
	localparam logic [3:0] CTRL_CMD_EN_LOW   = 4'h8;
	localparam logic [3:0] CTRL_DATA_EN_HIGH = 4'hD;
	localparam logic [3:0] CTRL_DATA_EN_LOW  = 4'h9;

	// High nibble of an ASCII digit.
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	// One double-dabble correction: every digit of five or more gets three added
	// so that the following left shift carries properly into the next digit.
	function automatic bcd_t bcd_adjust(input bcd_t d);
		bcd_t r;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = d[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

endpackage

// File: design/lcd_nibble_write_stream.sv
// Top level: turns commands, characters and decimal numbers into expander bytes.
//
// Each accepted item (start high while busy is low) produces a burst of expander
// bytes, one per clock cycle, each shown for exactly one cycle with strobe high;
// the receiver cannot stall, so it must take every byte as it appears. The final
// byte of an item carries last_byte. A command or character byte keeps the block
// busy while it gives 4 bytes. A number runs through a bit-serial binary-to-BCD
// converter, one bit per cycle, then drops leading zero digits one per cycle,
// then emits 4 bytes per digit.
// cmd 3 gives no bytes and does not make the block busy.
`include "assert_macros.svh"

module lcd_nibble_write_stream (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  lnws_pkg::cmd_t  cmd,
	input  lnws_pkg::value_t value,
	output logic            busy,
	output logic            strobe,
	output logic [7:0]      expander_byte,
	output logic            last_byte
);
	import lnws_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_TRIM = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [4:0] LAST_BIT = 5'(VALUE_W - 1);

	logic [1:0]   state_q;
	value_t       bin_q;
	bcd_t         bcd_q;
	logic [4:0]   bit_cnt_q;
	digit_cnt_t   dig_cnt_q;
	logic [1:0]   phase_q;
	logic         rs_q;
	logic         num_q;
	logic [7:0]   byte_q;
	logic         strobe_q;
	logic [7:0]   out_byte_q;
	logic         last_q;

	logic         accept;
	bcd_t         bcd_adj;
	logic [7:0]   cur_byte;
	logic [3:0]   cur_nibble;
	logic [3:0]   ctrl_nibble;
	logic         final_byte;

	assign accept  = start && (state_q == ST_IDLE);
	assign bcd_adj = bcd_adjust(bcd_q);

	// A number sends the top BCD digit as its ASCII code.
	assign cur_byte    = num_q ? {ASCII_DIGIT_HI, bcd_q[BCD_W-1 -: 4]} : byte_q;
	assign cur_nibble  = phase_q[1] ? cur_byte[3:0] : cur_byte[7:4];
	assign final_byte  = (phase_q == 2'd3) && (dig_cnt_q == 4'd1);

	always_comb begin
		unique case ({rs_q, phase_q[0]})
			2'b00:   ctrl_nibble = CTRL_CMD_EN_HIGH;
			2'b01:   ctrl_nibble = CTRL_CMD_EN_LOW;
			2'b10:   ctrl_nibble = CTRL_DATA_EN_HIGH;
			default: ctrl_nibble = CTRL_DATA_EN_LOW;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			phase_q   <= '0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= '0;
						if (cmd == CMD_INSTR || cmd == CMD_CHAR) begin
							dig_cnt_q <= 4'd1;
							state_q   <= ST_EMIT;
						end else if (cmd == CMD_NUMBER) begin
							bit_cnt_q <= '0;
							state_q   <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + 5'd1;
					if (bit_cnt_q == LAST_BIT) begin
						dig_cnt_q <= 4'(NUM_DIGITS);
						state_q   <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (bcd_q[BCD_W-1 -: 4] == 4'd0 && dig_cnt_q != 4'd1) begin
						dig_cnt_q <= dig_cnt_q - 4'd1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				default: begin
					strobe_q <= 1'b1;
					last_q   <= final_byte;
					phase_q  <= phase_q + 2'd1;
					if (phase_q == 2'd3) begin
						dig_cnt_q <= dig_cnt_q - 4'd1;
						if (dig_cnt_q == 4'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	// Datapath registers: operands, the shared BCD shifter and the output byte.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			out_byte_q <= {cur_nibble, ctrl_nibble};
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					bin_q  <= value;
					bcd_q  <= '0;
					byte_q <= value[7:0];
					rs_q   <= (cmd != CMD_INSTR);
					num_q  <= (cmd == CMD_NUMBER);
				end
			end
			ST_CONV: begin
				bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
				bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			end
			ST_TRIM: begin
				if (bcd_q[BCD_W-1 -: 4] == 4'd0 && dig_cnt_q != 4'd1) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
			default: begin
				if (phase_q == 2'd3) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
				end
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign strobe        = strobe_q;
	assign expander_byte = out_byte_q;
	assign last_byte     = last_q;

	`ASSERT_CLK(a_conv_holds, clk, arst_n,
		(state_q == ST_CONV && bit_cnt_q != LAST_BIT) |=> state_q == ST_CONV,
		"converter left before all bits were shifted in")
	`ASSERT_NEVER(a_emit_count, clk, arst_n, state_q == ST_EMIT && dig_cnt_q == 4'd0,
		"emitting with no digits left")
	`ASSERT_CLK(a_last_en_low, clk, arst_n,
		(strobe && last_byte) |-> (expander_byte[2] == 1'b0 && expander_byte[3]),
		"final byte of an item must have EN low and backlight on")
	`ASSERT_CLK(a_last_ends_burst, clk, arst_n,
		(strobe && last_byte) |-> $past(state_q) == ST_EMIT && state_q == ST_IDLE,
		"last byte flagged while the item is still running")

endmodule
